/* rtl/core/psq_pkg.sv */
// ----------------------------------------------------------------------------
// psq_pkg
// shared types, constants and counter helpers for the presence qualifier
// ----------------------------------------------------------------------------
package psq_pkg;

  localparam int COUNT_W = 16;
  localparam int CFG_W   = 16;
  localparam int CMP_W   = ((COUNT_W > CFG_W) ? COUNT_W : CFG_W) + 1;
  localparam int ADDR_W  = 3;

  typedef logic [COUNT_W-1:0] cnt_t;
  typedef logic [CFG_W-1:0]   cfg_word_t;

  // register indexes of the configuration port
  typedef enum logic [ADDR_W-1:0] {
    REG_TRIGGER_COUNT = 3'd0,
    REG_ERROR_COUNT   = 3'd1,
    REG_ENTER_WINDOW  = 3'd2,
    REG_EXIT_WINDOW   = 3'd3,
    REG_DWELL_SHORT   = 3'd4,
    REG_DWELL_LONG    = 3'd5,
    REG_ABSENT_HOLD   = 3'd6
  } reg_idx_t;

  localparam cfg_word_t RST_TRIGGER_COUNT = CFG_W'(50);
  localparam cfg_word_t RST_ERROR_COUNT   = CFG_W'(20);
  localparam cfg_word_t RST_ENTER_WINDOW  = CFG_W'(300);
  localparam cfg_word_t RST_EXIT_WINDOW   = CFG_W'(500);
  localparam cfg_word_t RST_DWELL_SHORT   = CFG_W'(500);
  localparam cfg_word_t RST_DWELL_LONG    = CFG_W'(6000);
  localparam cfg_word_t RST_ABSENT_HOLD   = CFG_W'(500);

  // qualifier phases
  typedef enum logic [2:0] {
    PH_INIT    = 3'd0,
    PH_ABSENT  = 3'd1,
    PH_ENTRY   = 3'd2,
    PH_PRESENT = 3'd3,
    PH_LEAVE   = 3'd4
  } phase_t;

  typedef struct packed {
    cfg_word_t trigger_count;
    cfg_word_t error_count;
    cfg_word_t enter_window;
    cfg_word_t exit_window;
    cfg_word_t dwell_short;
    cfg_word_t dwell_long;
    cfg_word_t absent_hold;
  } cfg_t;

  // presence and leaving flags of the sequencer
  typedef struct packed {
    logic present;
    logic leaving;
  } seq_flags_t;

  // dwell timer flags
  typedef struct packed {
    logic short_reached;
    logic long_reached;
    logic absent_held;
  } dwell_flags_t;

  typedef struct packed {
    logic present;
    logic leaving;
    logic dwell_short_reached;
    logic dwell_long_reached;
    logic absent_held;
    logic enter_pulse;
    logic exit_pulse;
  } result_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
  endfunction

  function automatic logic cnt_ge(input cnt_t c, input cfg_word_t t);
    return CMP_W'(c) >= CMP_W'(t);
  endfunction

  function automatic logic sum_ge(input cnt_t a, input cnt_t b, input cfg_word_t t);
    return (CMP_W'(a) + CMP_W'(b)) >= CMP_W'(t);
  endfunction

  function automatic cnt_t to_cnt(input cfg_word_t t);
    return COUNT_W'(t);
  endfunction

endpackage

/* rtl/core/presence_sensor_qualifier.sv */
// ----------------------------------------------------------------------------
// presence_sensor_qualifier
// qualifies a raw presence sensor into presence, leaving and dwell flags
// ----------------------------------------------------------------------------
// usage
//   input channel: one item per timer tick, in_sensor_level low means a
//   person is detected; accepted when in_valid is high and in_stall is low
//   result channel: one item per input item with seven flags, taken when
//   out_valid is high and out_stall is low
//   configuration: seven 16-bit thresholds written through cfg_we,
//   cfg_addr and cfg_wdata while the block is idle; unknown indexes ignored
// timing
//   the whole update for one item is a single pass of counter and compare
//   logic, registered into the output register, or the skid register if
//   a result waits; one item per cycle while in_stall is low, limited by
//   the state update: every counter and flag feeds back into the next item
// reset
//   rst_n is synchronous, active low; thresholds return to their defaults,
//   all counters and flags clear, the qualifier restarts in its init phase
// stall
//   a two-entry output buffer (output register plus skid register) keeps
//   taking items while one result waits; in_stall rises only when both
//   entries are occupied
// ----------------------------------------------------------------------------
module presence_sensor_qualifier (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_sensor_level,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_present,
  output logic                        out_leaving,
  output logic                        out_dwell_short_reached,
  output logic                        out_dwell_long_reached,
  output logic                        out_absent_held,
  output logic                        out_enter_pulse,
  output logic                        out_exit_pulse,
  // configuration port
  input  logic                        cfg_we,
  input  logic [psq_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [psq_pkg::CFG_W-1:0]   cfg_wdata
);
  import psq_pkg::*;

  cfg_t         cfg_r;
  seq_flags_t   seq_cur, seq_nxt;
  dwell_flags_t dwell_nxt;
  logic         step;
  logic         present_prev_r;
  result_t      res;
  result_t      out_r, skid_r;
  logic         out_valid_r, skid_valid_r;
  logic         pop;

  // one tick of work per accepted item
  assign step = in_valid && !in_stall;
  assign pop  = out_valid_r && !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_count <= RST_TRIGGER_COUNT;
      cfg_r.error_count   <= RST_ERROR_COUNT;
      cfg_r.enter_window  <= RST_ENTER_WINDOW;
      cfg_r.exit_window   <= RST_EXIT_WINDOW;
      cfg_r.dwell_short   <= RST_DWELL_SHORT;
      cfg_r.dwell_long    <= RST_DWELL_LONG;
      cfg_r.absent_hold   <= RST_ABSENT_HOLD;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TRIGGER_COUNT: cfg_r.trigger_count <= cfg_wdata;
        REG_ERROR_COUNT:   cfg_r.error_count   <= cfg_wdata;
        REG_ENTER_WINDOW:  cfg_r.enter_window  <= cfg_wdata;
        REG_EXIT_WINDOW:   cfg_r.exit_window   <= cfg_wdata;
        REG_DWELL_SHORT:   cfg_r.dwell_short   <= cfg_wdata;
        REG_DWELL_LONG:    cfg_r.dwell_long    <= cfg_wdata;
        REG_ABSENT_HOLD:   cfg_r.absent_hold   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // dwell timers look at the flags left by the previous item
  psq_dwell u_dwell (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cfg       (cfg_r),
    .seq_flags (seq_cur),
    .flags_nxt (dwell_nxt)
  );

  psq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .detected  (!in_sensor_level),
    .cfg       (cfg_r),
    .flags_r   (seq_cur),
    .flags_nxt (seq_nxt)
  );

  // edge pulses on the presence flag
  always_comb begin
    res.present             = seq_nxt.present;
    res.leaving             = seq_nxt.leaving;
    res.dwell_short_reached = dwell_nxt.short_reached;
    res.dwell_long_reached  = dwell_nxt.long_reached;
    res.absent_held         = dwell_nxt.absent_held;
    res.enter_pulse         = seq_nxt.present && !present_prev_r;
    res.exit_pulse          = !seq_nxt.present && present_prev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) present_prev_r <= 1'b0;
    else if (step) present_prev_r <= seq_nxt.present;
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= step;
      end else begin
        out_valid_r  <= step;
      end
    end else if (step) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (step) skid_r <= res;
      end else if (step) begin
        out_r <= res;
      end
    end else if (step) begin
      skid_r <= res;
    end
  end

  assign in_stall                = skid_valid_r;
  assign out_valid               = out_valid_r;
  assign out_present             = out_r.present;
  assign out_leaving             = out_r.leaving;
  assign out_dwell_short_reached = out_r.dwell_short_reached;
  assign out_dwell_long_reached  = out_r.dwell_long_reached;
  assign out_absent_held         = out_r.absent_held;
  assign out_enter_pulse         = out_r.enter_pulse;
  assign out_exit_pulse          = out_r.exit_pulse;

  // skid entry only fills behind a waiting output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // an item accepted into an empty buffer shows up next cycle
  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !out_valid_r) |=> out_valid_r)
    else $error("accepted item did not reach the output register");

  // enter and exit pulses are exclusive
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.enter_pulse && out_r.exit_pulse))
    else $error("enter and exit pulse together");

  // leaving only while presence holds
  a_leave_present: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.leaving) |-> out_r.present)
    else $error("leaving flag without presence");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed");

endmodule

/* rtl/core/psq_seq.sv */
// ----------------------------------------------------------------------------
// psq_seq
// five-phase entry / leave qualifier with high and low run counters
// ----------------------------------------------------------------------------
module psq_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                detected,
  input  psq_pkg::cfg_t       cfg,
  output psq_pkg::seq_flags_t flags_r,
  output psq_pkg::seq_flags_t flags_nxt
);
  import psq_pkg::*;

  phase_t phase_r, phase_nxt;
  cnt_t   act_r, act_nxt;
  cnt_t   inact_r, inact_nxt;
  cnt_t   act_inc, inact_inc;

  assign act_inc   = sat_inc(act_r);
  assign inact_inc = sat_inc(inact_r);

  // next phase and run counters
  always_comb begin
    phase_nxt = phase_r;
    act_nxt   = act_r;
    inact_nxt = inact_r;
    unique case (phase_r)
      PH_INIT: begin
        phase_nxt = PH_ABSENT;
      end
      PH_ABSENT: begin
        if (detected) begin
          act_nxt = act_inc;
          if (cnt_ge(act_inc, cfg.trigger_count)) begin
            act_nxt   = '0;
            inact_nxt = '0;
            phase_nxt = PH_ENTRY;
          end
        end else begin
          act_nxt = '0;
        end
      end
      PH_ENTRY: begin
        if (detected) begin
          act_nxt = act_inc;
          if (sum_ge(act_inc, inact_r, cfg.enter_window)) phase_nxt = PH_PRESENT;
        end else if (cnt_ge(inact_inc, cfg.error_count)) begin
          act_nxt   = '0;
          inact_nxt = '0;
          phase_nxt = PH_ABSENT;
        end else begin
          inact_nxt = inact_inc;
          if (sum_ge(act_r, inact_inc, cfg.enter_window)) phase_nxt = PH_PRESENT;
        end
      end
      PH_PRESENT: begin
        if (!detected) begin
          inact_nxt = inact_inc;
          if (cnt_ge(inact_inc, cfg.trigger_count)) begin
            act_nxt   = '0;
            inact_nxt = '0;
            phase_nxt = PH_LEAVE;
          end
        end else begin
          inact_nxt = '0;
        end
      end
      PH_LEAVE: begin
        if (!detected) begin
          inact_nxt = inact_inc;
          if (sum_ge(act_r, inact_inc, cfg.exit_window)) phase_nxt = PH_ABSENT;
        end else if (cnt_ge(act_inc, cfg.error_count)) begin
          act_nxt   = '0;
          inact_nxt = '0;
          phase_nxt = PH_PRESENT;
        end else begin
          act_nxt = act_inc;
          if (sum_ge(act_inc, inact_r, cfg.exit_window)) phase_nxt = PH_ABSENT;
        end
      end
      default: begin
        phase_nxt = PH_INIT;
      end
    endcase
  end

  // flags set by the phase being left
  always_comb begin
    flags_nxt = flags_r;
    unique case (phase_r)
      PH_INIT, PH_ABSENT, PH_ENTRY: begin
        flags_nxt.present = 1'b0;
        flags_nxt.leaving = 1'b0;
      end
      PH_PRESENT: begin
        flags_nxt.present = 1'b1;
        flags_nxt.leaving = 1'b0;
      end
      PH_LEAVE: begin
        flags_nxt.present = 1'b1;
        flags_nxt.leaving = 1'b1;
      end
      default: begin
        flags_nxt.leaving = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INIT;
      act_r   <= '0;
      inact_r <= '0;
      flags_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      act_r   <= act_nxt;
      inact_r <= inact_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

/* rtl/core/psq_dwell.sv */
// ----------------------------------------------------------------------------
// psq_dwell
// dwell and absence timers driven by the previous tick's flags
// ----------------------------------------------------------------------------
module psq_dwell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  psq_pkg::cfg_t         cfg,
  input  psq_pkg::seq_flags_t   seq_flags,
  output psq_pkg::dwell_flags_t flags_nxt
);
  import psq_pkg::*;

  cnt_t         dwell_r, dwell_nxt;
  cnt_t         absent_r, absent_nxt;
  dwell_flags_t flags_r;
  cnt_t         dwell_inc, absent_inc;

  assign dwell_inc  = sat_inc(dwell_r);
  assign absent_inc = sat_inc(absent_r);

  always_comb begin
    dwell_nxt  = dwell_r;
    absent_nxt = absent_r;
    flags_nxt  = flags_r;
    if (seq_flags.present) begin
      flags_nxt.absent_held = 1'b0;
      absent_nxt            = '0;
      if (!seq_flags.leaving) begin
        dwell_nxt = dwell_inc;
        // long test first, so a long dwell below the short one skips short
        if (cnt_ge(dwell_inc, cfg.dwell_long)) begin
          dwell_nxt                = to_cnt(cfg.dwell_long);
          flags_nxt.long_reached   = 1'b1;
        end else if (cnt_ge(dwell_inc, cfg.dwell_short)) begin
          flags_nxt.short_reached  = 1'b1;
        end
      end else if (!flags_r.short_reached) begin
        dwell_nxt = '0;
      end
    end else begin
      dwell_nxt               = '0;
      flags_nxt.short_reached = 1'b0;
      flags_nxt.long_reached  = 1'b0;
      absent_nxt              = absent_inc;
      if (cnt_ge(absent_inc, cfg.absent_hold)) begin
        absent_nxt            = to_cnt(cfg.absent_hold);
        flags_nxt.absent_held = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r  <= '0;
      absent_r <= '0;
      flags_r  <= '0;
    end else if (step) begin
      dwell_r  <= dwell_nxt;
      absent_r <= absent_nxt;
      flags_r  <= flags_nxt;
    end
  end

endmodule

/* tb/sv/presence_sensor_qualifier_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// presence_sensor_qualifier_test
// Drives sensor ticks into the presence qualifier and checks every result
// item against a cycle-free model of the phase sequencer and dwell timers.
// Directed sequences cover minimum, zero and reordered thresholds. A
// ceiling run keeps the largest thresholds out of reach. Random runs of
// steady levels use short thresholds. Random idling and back-pressure run
// on both channels except in the later random segments and the ceiling run.
// ----------------------------------------------------------------------------
module presence_sensor_qualifier_test;
  import psq_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  // settle time after the last result item, with margin
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_SEGMENTS = 4;
  localparam int SEGMENT_ITEMS = 150;
  localparam int SAT_RUN = 30;
  // index outside the register map, the block must ignore it
  localparam logic [ADDR_W-1:0] UNUSED_REG = 3'd7;
  localparam cfg_word_t CFG_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_sensor_level = 1'b1;

  // result channel
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_present;
  logic out_leaving;
  logic out_dwell_short_reached;
  logic out_dwell_long_reached;
  logic out_absent_held;
  logic out_enter_pulse;
  logic out_exit_pulse;

  // configuration port
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  cfg_word_t cfg_wdata = '0;

  // idling percentages for sender gaps and receiver stalls
  int gap_pct = 12;
  int stall_pct = 46;
  int fail_count = 0;
  int cycle_count = 0;

  // model copy of the thresholds, tracks every register write
  cfg_t thr = '{RST_TRIGGER_COUNT, RST_ERROR_COUNT, RST_ENTER_WINDOW, RST_EXIT_WINDOW,
                RST_DWELL_SHORT, RST_DWELL_LONG, RST_ABSENT_HOLD};

  // model state: sequencer phase and runs of detected / clear ticks
  phase_t ph = PH_INIT;
  cnt_t det_run = '0;
  cnt_t quiet_run = '0;
  // dwell timers
  cnt_t dwell_ticks = '0;
  cnt_t absent_ticks = '0;
  logic present_q = 1'b0;
  logic leaving_q = 1'b0;
  logic short_q = 1'b0;
  logic long_q = 1'b0;
  logic absent_q = 1'b0;
  // presence seen on the previous tick, source of the edge pulses
  logic present_last = 1'b0;

  // predicted flags, oldest first, one entry per accepted item
  result_t expected_flags_q[$];
  result_t want;

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  presence_sensor_qualifier u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_sensor_level         (in_sensor_level),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_present             (out_present),
    .out_leaving             (out_leaving),
    .out_dwell_short_reached (out_dwell_short_reached),
    .out_dwell_long_reached  (out_dwell_long_reached),
    .out_absent_held         (out_absent_held),
    .out_enter_pulse         (out_enter_pulse),
    .out_exit_pulse          (out_exit_pulse),
    .cfg_we                  (cfg_we),
    .cfg_addr                (cfg_addr),
    .cfg_wdata               (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // qualifier model
  // ---------------------------------------------------------------------------

  // counters stop at all ones instead of wrapping
  function automatic cnt_t bump(input cnt_t c);
    return (c == '1) ? c : c + cnt_t'(1);
  endfunction

  // window test on the sum, one bit wider so the sum cannot wrap
  function automatic logic window_done(input cnt_t a, input cnt_t b, input cfg_word_t t);
    return ({1'b0, a} + {1'b0, b}) >= {1'b0, t};
  endfunction

  // advance the model by one tick and return the flags it produces
  task automatic qualify_tick(input logic level, output result_t r);
    logic detected;
    detected = ~level;

    // dwell timers see the flags left by the previous tick
    if (present_q) begin
      absent_q = 1'b0;
      absent_ticks = '0;
      if (!leaving_q) begin
        dwell_ticks = bump(dwell_ticks);
        // long test first, so a long limit at or below the short one skips short
        if (dwell_ticks >= thr.dwell_long) begin
          dwell_ticks = thr.dwell_long;
          long_q = 1'b1;
        end else if (dwell_ticks >= thr.dwell_short) begin
          short_q = 1'b1;
        end
      end else if (!short_q) begin
        // leave judging before the short dwell restarts the dwell count
        dwell_ticks = '0;
      end
    end else begin
      dwell_ticks = '0;
      short_q = 1'b0;
      long_q = 1'b0;
      absent_ticks = bump(absent_ticks);
      if (absent_ticks >= thr.absent_hold) begin
        absent_ticks = thr.absent_hold;
        absent_q = 1'b1;
      end
    end

    case (ph)
      PH_INIT: begin
        present_q = 1'b0;
        leaving_q = 1'b0;
        ph = PH_ABSENT;
      end
      PH_ABSENT: begin
        present_q = 1'b0;
        leaving_q = 1'b0;
        if (detected) begin
          det_run = bump(det_run);
          if (det_run >= thr.trigger_count) begin
            det_run = '0;
            quiet_run = '0;
            ph = PH_ENTRY;
          end
        end else begin
          det_run = '0;
        end
      end
      PH_ENTRY: begin
        present_q = 1'b0;
        leaving_q = 1'b0;
        if (detected) det_run = bump(det_run);
        else quiet_run = bump(quiet_run);
        // too many clear ticks abort entry, else the window decides
        if (!detected && quiet_run >= thr.error_count) begin
          det_run = '0;
          quiet_run = '0;
          ph = PH_ABSENT;
        end else if (window_done(det_run, quiet_run, thr.enter_window)) begin
          ph = PH_PRESENT;
        end
      end
      PH_PRESENT: begin
        present_q = 1'b1;
        leaving_q = 1'b0;
        if (!detected) begin
          quiet_run = bump(quiet_run);
          if (quiet_run >= thr.trigger_count) begin
            det_run = '0;
            quiet_run = '0;
            ph = PH_LEAVE;
          end
        end else begin
          quiet_run = '0;
        end
      end
      PH_LEAVE: begin
        present_q = 1'b1;
        leaving_q = 1'b1;
        if (detected) det_run = bump(det_run);
        else quiet_run = bump(quiet_run);
        // mirror of entry: detected ticks abort leaving
        if (detected && det_run >= thr.error_count) begin
          det_run = '0;
          quiet_run = '0;
          ph = PH_PRESENT;
        end else if (window_done(det_run, quiet_run, thr.exit_window)) begin
          ph = PH_ABSENT;
        end
      end
      default: begin
        ph = PH_INIT;
        leaving_q = 1'b0;
      end
    endcase

    r = '0;
    r.present = present_q;
    r.leaving = leaving_q;
    r.dwell_short_reached = short_q;
    r.dwell_long_reached = long_q;
    r.absent_held = absent_q;
    if (present_last != present_q) begin
      r.enter_pulse = present_q;
      r.exit_pulse = ~present_q;
      present_last = present_q;
    end
  endtask

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  // offer one sensor tick, hold it until accepted, then predict its flags
  task automatic send_level(input logic level);
    result_t r;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sensor_level <= level;
    do @(posedge clk); while (in_stall);
    qualify_tick(level, r);
    expected_flags_q.push_back(r);
  endtask

  task automatic send_run(input logic level, input int n);
    repeat (n) send_level(level);
  endtask

  // stop sending and let every predicted item come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_flags_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; the enable stays up for back-to-back writes
  task automatic write_reg(input logic [ADDR_W-1:0] idx, input cfg_word_t v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      REG_TRIGGER_COUNT: thr.trigger_count = v;
      REG_ERROR_COUNT:   thr.error_count = v;
      REG_ENTER_WINDOW:  thr.enter_window = v;
      REG_EXIT_WINDOW:   thr.exit_window = v;
      REG_DWELL_SHORT:   thr.dwell_short = v;
      REG_DWELL_LONG:    thr.dwell_long = v;
      REG_ABSENT_HOLD:   thr.absent_hold = v;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input cfg_t s);
    write_reg(REG_TRIGGER_COUNT, s.trigger_count);
    write_reg(REG_ERROR_COUNT, s.error_count);
    write_reg(REG_ENTER_WINDOW, s.enter_window);
    write_reg(REG_EXIT_WINDOW, s.exit_window);
    write_reg(REG_DWELL_SHORT, s.dwell_short);
    write_reg(REG_DWELL_LONG, s.dwell_long);
    write_reg(REG_ABSENT_HOLD, s.absent_hold);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_flag(input string name, input logic exp, input logic act);
    if (act !== exp) begin
      $error("%s: expected %0b, got %0b", name, exp, act);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_flags_q.size() == 0) begin
        $error("result item with no sensor item pending");
        fail_count++;
      end else begin
        want = expected_flags_q.pop_front();
        check_flag("present", want.present, out_present);
        check_flag("leaving", want.leaving, out_leaving);
        check_flag("dwell_short_reached", want.dwell_short_reached, out_dwell_short_reached);
        check_flag("dwell_long_reached", want.dwell_long_reached, out_dwell_long_reached);
        check_flag("absent_held", want.absent_held, out_absent_held);
        check_flag("enter_pulse", want.enter_pulse, out_enter_pulse);
        check_flag("exit_pulse", want.exit_pulse, out_exit_pulse);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset thresholds: init phase, then absent counting with both levels
  task automatic test_reset_defaults();
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    send_level(1'b1);
    drain_results();
  endtask

  // every threshold at one: each phase change happens on a single tick
  task automatic test_min_thresholds();
    apply_setting('{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1});
    send_run(1'b1, 2);
    send_level(1'b0);   // trigger, into entry judging
    send_level(1'b1);   // one clear tick aborts entry
    send_run(1'b0, 3);  // trigger, window, then present with enter pulse
    send_level(1'b1);   // trigger, into leave judging
    send_level(1'b0);   // one detected tick aborts leaving
    send_run(1'b1, 3);  // leave again, window, exit pulse
    drain_results();
  endtask

  // zero thresholds are met at their first test; a stray index changes nothing
  task automatic test_zero_thresholds();
    write_reg(UNUSED_REG, 16'h5a5a);
    apply_setting('0);
    send_level(1'b1);
    send_level(1'b0);
    send_level(1'b1);
    send_level(1'b0);
    send_run(1'b1, 2);
    drain_results();
  endtask

  task automatic test_dwell_order();
    // long limit below the short one: long flag sets, short stays clear
    apply_setting('{16'd1, 16'd2, 16'd1, 16'd3, 16'd5, 16'd3, 16'd2});
    send_run(1'b1, 3);
    send_run(1'b0, 6);
    drain_results();
    // leaving after the short dwell holds the count, before it clears it
    apply_setting('{16'd1, 16'd2, 16'd1, 16'd3, 16'd2, 16'd9, 16'd2});
    send_run(1'b0, 4);
    send_run(1'b1, 2);
    send_level(1'b0);
    send_run(1'b1, 4);
    drain_results();
  endtask

  // short random thresholds so that random runs walk through every phase
  task automatic test_random_runs();
    cfg_t s;
    int sent;
    int len;
    logic level;
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      // sender light / receiver heavy, then swapped, then no idling at all
      case (seg)
        0: begin gap_pct = 12; stall_pct = 46; end
        1: begin gap_pct = 46; stall_pct = 12; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      drain_results();
      s.trigger_count = cfg_word_t'($urandom_range(1, 8));
      s.error_count = cfg_word_t'($urandom_range(1, 6));
      s.enter_window = cfg_word_t'($urandom_range(1, 20));
      s.exit_window = cfg_word_t'($urandom_range(1, 20));
      s.dwell_short = cfg_word_t'($urandom_range(1, 40));
      s.dwell_long = cfg_word_t'($urandom_range(1, 60));
      s.absent_hold = cfg_word_t'($urandom_range(1, 30));
      apply_setting(s);
      sent = 0;
      while (sent < SEGMENT_ITEMS) begin
        level = 1'($urandom_range(0, 1));
        // mostly steady runs that qualify, some glitches of one or two ticks
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 12);
        send_run(level, len);
        sent += len;
        // second segment: sender holds off mid-segment until the pipe is empty
        if (seg == 1 && sent >= SEGMENT_ITEMS / 2 && sent - len < SEGMENT_ITEMS / 2)
          drain_results();
      end
    end
    drain_results();
  endtask

  // ceiling thresholds: absent and dwell flags stay clear over long runs
  task automatic test_counter_saturation();
    gap_pct = 0;
    stall_pct = 0;
    apply_setting('{16'd1, CFG_MAX, 16'd1, 16'd1, CFG_MAX, CFG_MAX, CFG_MAX});
    send_run(1'b1, SAT_RUN);
    send_run(1'b0, SAT_RUN);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[presence_sensor_qualifier] ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_min_thresholds();
    test_zero_thresholds();
    test_dwell_order();
    test_random_runs();
    test_counter_saturation();
    drain_results();
    if (fail_count == 0)
      $display("[presence_sensor_qualifier] OK");
    else
      $display("[presence_sensor_qualifier] ERROR");
    $finish;
  end

endmodule
